/* hdl/assert_macros.svh */
// Assertion macros for the LED PWM frame generator RTL (included by lpwm_back).
// Uses the clk and rst_n names of the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LPWM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LPWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LPWM_ASSERT(lbl, cond, msg)
`define LPWM_ASSERT_IMP(lbl, ante, cons, msg)
`define LPWM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/lpwm_pkg.sv */
// Shared types and constants for the bicolor LED PWM frame generator.
// No dependencies; used by lpwm_queue, lpwm_front, lpwm_back and the top module.
package lpwm_pkg;

  localparam int NUM_LEDS_DEF    = 16;
  localparam int FRAME_BYTES_DEF = 4;
  localparam int PWM_W           = 4;
  localparam int QDEPTH          = 2;

  // Command codes as they arrive on the input channel.
  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_SET,
    OP_FRAME,
    OP_CLEAR
  } op_kind_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_kind_t   op;
    logic       bad;
    logic [7:0] idx;
    logic [7:0] green;
    logic [3:0] red;
  } op_t;

endpackage

/* hdl/lpwm_in_if.sv */
// Input channel of the LED PWM frame generator: valid/ready plus command fields.
// No dependencies.
interface lpwm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] led_index;
  logic [7:0] green_duty;
  logic [7:0] red_duty;

  modport source (output valid, cmd, led_index, green_duty, red_duty, input ready);
  modport sink   (input valid, cmd, led_index, green_duty, red_duty, output ready);
endinterface

/* hdl/lpwm_out_if.sv */
// Result channel of the LED PWM frame generator: valid/ready plus result fields.
// No dependencies.
interface lpwm_out_if;
  logic       valid;
  logic       ready;
  logic       is_frame_byte;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic       status;

  modport source (output valid, is_frame_byte, frame_byte, last_byte, status, input ready);
  modport sink   (input valid, is_frame_byte, frame_byte, last_byte, status, output ready);
endinterface

/* hdl/lpwm_queue.sv */
// Short queue of classified items between the front and back parts.
// Depends on lpwm_pkg.
module lpwm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpwm_pkg::op_t  push_data,
  output logic           push_ready,
  input  logic           pop,
  output logic           head_valid,
  output lpwm_pkg::op_t  head
);

  localparam int PTR_W = (lpwm_pkg::QDEPTH > 1) ? $clog2(lpwm_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(lpwm_pkg::QDEPTH + 1);

  lpwm_pkg::op_t    q_r [lpwm_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    push_ready = cnt_r != CNT_W'(lpwm_pkg::QDEPTH);
    head_valid = cnt_r != '0;
    head       = q_r[rd_ptr_r];
    do_push    = push && push_ready;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(lpwm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(lpwm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/lpwm_front.sv */
// Front part: accepts input items, decodes the command and range-checks the LED index.
// Depends on lpwm_pkg and lpwm_in_if.
module lpwm_front #(
  parameter int NUM_LEDS = lpwm_pkg::NUM_LEDS_DEF
) (
  lpwm_in_if.sink        in_ch,
  output logic           push,
  output lpwm_pkg::op_t  push_data,
  input  logic           push_ready
);

  always_comb begin
    in_ch.ready     = push_ready;
    push            = 1'b0;
    push_data.op    = lpwm_pkg::OP_SET;
    push_data.bad   = in_ch.led_index >= 8'(NUM_LEDS);
    push_data.idx   = in_ch.led_index;
    push_data.green = in_ch.green_duty;
    push_data.red   = in_ch.red_duty[3:0];
    case (in_ch.cmd)
      lpwm_pkg::CMD_SET: begin
        push = in_ch.valid;
      end
      lpwm_pkg::CMD_FRAME: begin
        push         = in_ch.valid;
        push_data.op = lpwm_pkg::OP_FRAME;
      end
      lpwm_pkg::CMD_CLEAR: begin
        push         = in_ch.valid;
        push_data.op = lpwm_pkg::OP_CLEAR;
      end
      default: begin
        // Unused command: the item is taken and dropped without a result.
        push = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/lpwm_back.sv */
// Back part: holds live and mirrored duties and the PWM count, executes queued items
// and drives the registered result channel. Depends on lpwm_pkg, lpwm_out_if, macros.
`include "assert_macros.svh"

module lpwm_back #(
  parameter int NUM_LEDS    = lpwm_pkg::NUM_LEDS_DEF,
  parameter int FRAME_BYTES = lpwm_pkg::FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  lpwm_pkg::op_t  head,
  output logic           pop,
  lpwm_out_if.source     out_ch
);

  localparam int LED_W  = $clog2(NUM_LEDS);
  localparam int BYTE_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int SEL_W  = BYTE_W + 2;
  localparam int IW     = ((SEL_W > LED_W) ? SEL_W : LED_W) + 1;
  localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(FRAME_BYTES - 1);

  logic [7:0]                 live_g_r   [NUM_LEDS];
  logic [3:0]                 live_r_r   [NUM_LEDS];
  logic [7:0]                 mirror_g_r [NUM_LEDS];
  logic [3:0]                 mirror_r_r [NUM_LEDS];
  logic [lpwm_pkg::PWM_W-1:0] pwm_r;
  logic [BYTE_W-1:0]          byte_r;

  logic       out_valid_r;
  logic       is_frame_r, is_frame_nxt;
  logic [7:0] frame_byte_r, frame_byte_nxt;
  logic       last_r, last_nxt;
  logic       status_r, status_nxt;

  logic emit, is_frame, is_last, copy;

  always_comb begin
    logic [IW-1:0] led_sel;
    logic [7:0]    g;
    logic [3:0]    r;
    emit     = head_valid && (!out_valid_r || out_ch.ready);
    is_frame = head.op == lpwm_pkg::OP_FRAME;
    is_last  = byte_r == LAST_BYTE;
    // A new PWM period takes its duties straight from the live values.
    copy     = is_frame && (pwm_r == '0) && (byte_r == '0);
    pop      = emit && (!is_frame || is_last);

    frame_byte_nxt = '0;
    g              = '0;
    r              = '0;
    for (int j = 0; j < 4; j++) begin
      led_sel = IW'({byte_r, 2'(j)});
      if (led_sel < IW'(NUM_LEDS)) begin
        g = copy ? live_g_r[led_sel[LED_W-1:0]] : mirror_g_r[led_sel[LED_W-1:0]];
        r = copy ? live_r_r[led_sel[LED_W-1:0]] : mirror_r_r[led_sel[LED_W-1:0]];
        frame_byte_nxt[7-2*j] = {4'b0000, pwm_r} < g;
        frame_byte_nxt[6-2*j] = pwm_r > (4'hF - r);
      end
    end

    is_frame_nxt = is_frame;
    last_nxt     = is_frame && is_last;
    status_nxt   = (head.op == lpwm_pkg::OP_SET) && head.bad;
    if (!is_frame) begin
      frame_byte_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pwm_r       <= '0;
      byte_r      <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        live_g_r[i]   <= '0;
        live_r_r[i]   <= '0;
        mirror_g_r[i] <= '0;
        mirror_r_r[i] <= '0;
      end
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        case (head.op)
          lpwm_pkg::OP_SET: begin
            if (!head.bad) begin
              live_g_r[head.idx[LED_W-1:0]] <= head.green;
              live_r_r[head.idx[LED_W-1:0]] <= head.red;
            end
          end
          lpwm_pkg::OP_CLEAR: begin
            for (int i = 0; i < NUM_LEDS; i++) begin
              live_g_r[i] <= '0;
              live_r_r[i] <= '0;
            end
          end
          lpwm_pkg::OP_FRAME: begin
            if (copy) begin
              for (int i = 0; i < NUM_LEDS; i++) begin
                mirror_g_r[i] <= live_g_r[i];
                mirror_r_r[i] <= live_r_r[i];
              end
            end
            if (is_last) begin
              byte_r <= '0;
              pwm_r  <= pwm_r + 1'b1;
            end else begin
              byte_r <= byte_r + 1'b1;
            end
          end
          default: begin
            byte_r <= byte_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_frame_r   <= is_frame_nxt;
      frame_byte_r <= frame_byte_nxt;
      last_r       <= last_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.is_frame_byte = is_frame_r;
  assign out_ch.frame_byte    = frame_byte_r;
  assign out_ch.last_byte     = last_r;
  assign out_ch.status        = status_r;

  `LPWM_ASSERT(a_byte_range, byte_r <= LAST_BYTE, "frame byte counter out of range")
  `LPWM_ASSERT_IMP(a_mid_frame, byte_r != '0, head_valid && is_frame, "frame lost its item")
  `LPWM_ASSERT_NEXT(a_pwm_hold, !(emit && is_frame && is_last), $stable(pwm_r), "pwm moved early")

endmodule

/* hdl/bicolor_led_pwm_frame_generator.sv */
// Sixteen-channel green/red LED PWM frame generator for shift-register chains.
// A set or clear item yields one status result through the registered output, so
// such items stream at one per cycle while out_ch.ready is high. A frame item yields
// FRAME_BYTES frame bytes, one per cycle through the single output register while
// out_ch.ready is high, and holds the back part until its last byte; the last byte
// carries last_byte for the latch. A two-entry queue takes new items during a frame.
// Depends on lpwm_pkg, lpwm_in_if, lpwm_out_if, lpwm_front, lpwm_queue, lpwm_back.
module bicolor_led_pwm_frame_generator #(
  parameter int NUM_LEDS    = lpwm_pkg::NUM_LEDS_DEF,
  parameter int FRAME_BYTES = lpwm_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lpwm_in_if.sink     in_ch,
  lpwm_out_if.source  out_ch
);

  logic          push, push_ready, pop, head_valid;
  lpwm_pkg::op_t push_data, head;

  lpwm_front #(
    .NUM_LEDS (NUM_LEDS)
  ) u_front (
    .in_ch      (in_ch),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  lpwm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lpwm_back #(
    .NUM_LEDS    (NUM_LEDS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
